>>> sv/additive_hash_linear_probe_insert_assert.svh
// Assertion macros shared by the checker of the linear-probe insert block.
// Needs nothing else; include by bare file name.
`ifndef ADDITIVE_HASH_LINEAR_PROBE_INSERT_ASSERT_SVH
`define ADDITIVE_HASH_LINEAR_PROBE_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ahlp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ahlp check failed");

`endif

>>> sv/ahlp_pkg.sv
// Package for the linear-probe insert block: sizes, beat types, controller links.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ahlp_pkg;

    localparam int SLOT_BITS   = 6;
    localparam int SLOT_COUNT  = 1 << SLOT_BITS;
    localparam int RECORD_BITS = 32;
    localparam int CHAR_BITS   = 8;
    localparam int HANDLE_BITS = 32;
    localparam int INDEX_BITS  = 6;

    typedef struct packed {
        logic [CHAR_BITS-1:0]   name_char;
        logic                   name_last;
        logic [HANDLE_BITS-1:0] record_handle;
    } t_in_beat;

    typedef struct packed {
        logic [INDEX_BITS-1:0] slot_index;
        logic                  insert_status;
    } t_out_beat;

    typedef enum logic {
        ST_STORED = 1'b0,
        ST_FULL   = 1'b1
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take an accepted character beat
        logic advance;  // step the probe to the next slot
        logic store;    // write the record at the probe slot
        logic full;     // report the table full
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;  // probe slot is unoccupied
        logic probe_end;  // probe is on the last slot of the round
    } t_dp_sts;

    function automatic logic [INDEX_BITS-1:0] to_index(input logic [SLOT_BITS-1:0] slot);
        logic [SLOT_BITS+INDEX_BITS-1:0] wide;
        wide = {{INDEX_BITS{1'b0}}, slot};
        return wide[INDEX_BITS-1:0];
    endfunction

    function automatic logic [RECORD_BITS-1:0] to_record(
        input logic [HANDLE_BITS-1:0] handle
    );
        logic [RECORD_BITS+HANDLE_BITS-1:0] wide;
        wide = {{RECORD_BITS{1'b0}}, handle};
        return wide[RECORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/ahlp_ctrl.sv
// Controller of the linear-probe insert block: idle / probe state machine.
// Depends on ahlp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ahlp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             i_last,
    input  wire ahlp_pkg::t_dp_sts i_sts,
    output logic                  busy,
    output ahlp_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PROBE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                busy = 1'b1;
                if (i_sts.slot_free) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.probe_end) begin
                    o_cmd.full = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> sv/ahlp_dp.sv
// Datapath of the linear-probe insert block: running hash, occupancy map,
// record store, probe pointer and result register. Depends on ahlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahlp_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ahlp_pkg::t_in_beat i_item,
    input  wire ahlp_pkg::t_dp_cmd  i_cmd,
    output ahlp_pkg::t_dp_sts      o_sts,
    output logic                   o_valid,
    output ahlp_pkg::t_out_beat    o_result
);

    localparam int SB = ahlp_pkg::SLOT_BITS;
    localparam int CB = ahlp_pkg::CHAR_BITS;

    logic [SB-1:0]                   r_hash;
    logic [ahlp_pkg::SLOT_COUNT-1:0] r_occ;
    logic [ahlp_pkg::RECORD_BITS-1:0] r_record [ahlp_pkg::SLOT_COUNT];
    logic [SB-1:0]                   r_probe;
    logic [SB-1:0]                   r_home;
    logic [SB-1:0]                   r_count;
    logic [ahlp_pkg::RECORD_BITS-1:0] r_handle;
    logic                            r_valid;
    ahlp_pkg::t_out_beat             r_result;

    logic [SB+CB-1:0] w_sum;
    logic [SB-1:0]    w_home;

    // Table size is a power of two, so the modulo is a truncation.
    assign w_sum  = {{CB{1'b0}}, r_hash} + {{SB{1'b0}}, i_item.name_char};
    assign w_home = w_sum[SB-1:0];

    assign o_sts.slot_free = !r_occ[r_probe];
    assign o_sts.probe_end = (r_count == SB'(ahlp_pkg::SLOT_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.store || i_cmd.full;
            if (i_cmd.load) begin
                r_hash <= i_item.name_last ? '0 : w_home;
            end
            if (i_cmd.store) begin
                r_occ[r_probe] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_item.name_last) begin
            r_probe  <= w_home;
            r_home   <= w_home;
            r_count  <= '0;
            r_handle <= ahlp_pkg::to_record(i_item.record_handle);
        end else if (i_cmd.advance) begin
            r_probe <= r_probe + SB'(1);
            r_count <= r_count + SB'(1);
        end
        if (i_cmd.store) begin
            r_result.slot_index    <= ahlp_pkg::to_index(r_probe);
            r_result.insert_status <= ahlp_pkg::ST_STORED;
        end else if (i_cmd.full) begin
            r_result.slot_index    <= ahlp_pkg::to_index(r_home);
            r_result.insert_status <= ahlp_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_record[r_probe] <= r_handle;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> sv/additive_hash_linear_probe_insert.sv
// A beat that is not the last character updates the hash register; busy stays low.
// A last-character beat holds busy while the probe walks from its home slot, one slot checked
// per cycle, to a free slot or the round's last slot; the result strobe shows in the cycle after
// the last probe. The next beat is taken in the cycle the strobe shows; the receiver cannot stall.
// Reset (synchronous, active low): hash to zero, all 64 occupancy bits clear at once, no sweep.
// Top level of the additive-hash linear-probe insert block; depends on ahlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module additive_hash_linear_probe_insert (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire ahlp_pkg::t_in_beat i_item,
    output logic                    busy,
    output logic                    o_valid,
    output ahlp_pkg::t_out_beat     o_result
);

    // Controller/datapath link: commands go down, probe status comes back.
    ahlp_pkg::t_dp_cmd w_cmd;
    ahlp_pkg::t_dp_sts w_sts;

    // Sequence the beat: load the character, then walk the probe until a
    // free slot turns up or the probe reaches the last slot of its round.
    ahlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_item.name_last),
        .i_sts   (w_sts),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Hold the running hash, the occupancy map and the record store; drive
    // the one-cycle result strobe from a register so it never blocks input.
    ahlp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> sv/ahlp_chk.sv
// Port-level checker for the linear-probe insert block, bound to the top level.
// Depends on ahlp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "additive_hash_linear_probe_insert_assert.svh"

module ahlp_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire ahlp_pkg::t_in_beat  i_item,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire ahlp_pkg::t_out_beat o_result
);

    logic w_take_mid;
    logic w_take_last;

    assign w_take_mid  = start && !busy && !i_item.name_last;
    assign w_take_last = start && !busy && i_item.name_last;

    // A middle character never starts a probe nor causes a result.
    `AHLP_ASSERT_NEXT(a_mid_no_work, i_clk, i_rst_n, w_take_mid, !busy && !o_valid)
    // A last character always starts a probe.
    `AHLP_ASSERT_NEXT(a_last_probes, i_clk, i_rst_n, w_take_last, busy)
    // The probe ends exactly with a result beat.
    `AHLP_ASSERT_NOW(a_end_reports, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid)
    // A result beat shows only once the block is free again.
    `AHLP_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // A result beat carries known slot and status bits.
    `AHLP_ASSERT_NOW(a_result_known, i_clk, i_rst_n, o_valid, !$isunknown(o_result))

endmodule

bind additive_hash_linear_probe_insert ahlp_chk u_ahlp_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
